// ===== src/vibration_rolling_variance_assert.svh =====
// Assertion macros shared by the checker
`ifndef VIBRATION_ROLLING_VARIANCE_ASSERT_SVH
`define VIBRATION_ROLLING_VARIANCE_ASSERT_SVH
`define VRV_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define VRV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/vrv_pkg.sv =====
// Package: widths and helpers for the rolling variance block
`default_nettype none
package vrv_pkg;
   localparam int MaxWindowDefault = 64;
   localparam int CfgWidth = 7;
   localparam int MagWidth = 16;
   localparam int VarWidth = 32;
   localparam logic [CfgWidth-1:0] WindowReset = 7'd16;
endpackage
`default_nettype wire

// ===== src/vrv_ram.sv =====
// Generic single-port-write RAM with registered read
`default_nettype none
module vrv_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]              rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/vrv_isqrt.sv =====
// Bit-serial integer square root, one root bit per cycle
`default_nettype none
module vrv_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [35:0] radicand,
   output logic             done,
   output logic [17:0]      root
);
   logic [35:0] rem_ff, rem_in;
   logic [35:0] root_ff, root_in;
   logic [35:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic [35:0] trial;
   always_comb begin
      rem_in = rem_ff; root_in = root_ff; bit_in = bit_ff; busy_in = busy_ff;
      trial = root_ff + bit_ff;
      if (start) begin
         rem_in = radicand; root_in = '0; bit_in = 36'h4_0000_0000; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) busy_in = 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      rem_ff <= rem_in; root_ff <= root_in; bit_ff <= bit_in;
   end
   assign done = busy_ff && bit_ff[0];
   assign root = root_in[17:0];
endmodule
`default_nettype wire

// ===== src/vrv_divider.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit saturated quotient
`default_nettype none
module vrv_divider #(
   parameter int NumWidth = 48,
   parameter int DenWidth = 20
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NumWidth-1:0] numer,
   input  wire logic [DenWidth-1:0] denom,
   output logic                     done,
   output logic [31:0]              quot
);
   localparam int CntW = $clog2(NumWidth + 1);
   logic [NumWidth-1:0] q_ff, q_in;
   logic [DenWidth:0]   r_ff, r_in;
   logic [DenWidth-1:0] d_ff, d_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [DenWidth:0]   shifted;
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      shifted = {r_ff[DenWidth-1:0], q_ff[NumWidth-1]};
      if (start) begin
         q_in = numer; r_in = '0; d_in = denom;
         cnt_in = CntW'(NumWidth); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, d_ff}) begin
            r_in = shifted - {1'b0, d_ff};
            q_in = {q_ff[NumWidth-2:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) busy_in = 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
   end
   assign done = busy_ff && (cnt_ff == CntW'(1));
   assign quot = (q_in >> 32) != '0 ? 32'hFFFF_FFFF : q_in[31:0];
endmodule
`default_nettype wire

// ===== src/vibration_rolling_variance.sv =====
// Top level: rolling magnitude variance over three-axis acceleration
// Usage: samples enter on req_ (tdata = accel_x, accel_y, accel_z, low first).
// Each transfer yields one result on rsp_ with the three magnitudes and the
// floored sample variance of each rolling window. csr_ writes the window
// length (0 acts as 1, above MAX_WINDOW acts as MAX_WINDOW) and empties the
// windows; csr_ready is high only while idle with no sample offered.
// Steps after the sample transfer: two 18-step square roots (S_SQ1, S_SQ2),
// ring read and update (S_RD, S_RD2, S_UPD), and per window S_VPREP, S_VMUL,
// S_VDIV and a 47-step divide (default MAX_WINDOW); a window whose variance
// is zero skips the divide. After the result transfer the block returns to
// idle before it takes the next sample.
// req_tready is low while a sample is in work and while a result waits.
// Reset: window length 16, windows empty, ring contents left unwritten.
// A stalled receiver holds rsp_ data steady; no new sample is taken until
// the result is transferred.
`default_nettype none
module vibration_rolling_variance #(
   parameter int MAX_WINDOW = vrv_pkg::MaxWindowDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [47:0]   req_tdata,   // accel_x, accel_y, accel_z
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [143:0]       rsp_tdata,   // axial_mag, axial_variance, lateral_mag,
                                           // lateral_variance, total_mag, total_variance
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [vrv_pkg::CfgWidth-1:0] csr_data // window_len
);
   import vrv_pkg::*;

   localparam int AW  = $clog2(MAX_WINDOW);
   localparam int NW  = $clog2(MAX_WINDOW + 1);
   localparam int SW  = 16 + NW;
   localparam int QW  = 32 + NW;
   localparam int NUMW = QW + NW + 1;
   localparam int DENW = 2 * NW;

   localparam logic [3:0] S_IDLE = 4'd0, S_SQ1 = 4'd1, S_SQ2 = 4'd2, S_RD = 4'd3,
      S_RD2 = 4'd4, S_UPD = 4'd5, S_VPREP = 4'd6, S_VMUL = 4'd7, S_VDIV = 4'd8,
      S_VWAIT = 4'd9, S_OUT = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [CfgWidth-1:0] wlen_ff;
   logic [NW-1:0] len_ff, len_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [NW-1:0] fill_ff, fill_in;
   logic [SW-1:0] sum_ff [3];
   logic [QW-1:0] sq_ff [3];
   logic [SW-1:0] sum_in [3];
   logic [QW-1:0] sq_in [3];
   logic [15:0] mag_ff [3];
   logic [15:0] mag_in [3];
   logic [31:0] var_ff [3];
   logic [31:0] var_in [3];
   logic [1:0]  ch_ff, ch_in;
   logic        full_ff, full_in;
   logic [NUMW-1:0] num_ff, num_in;
   logic [DENW-1:0] den_ff, den_in;
   logic        zero_ff, zero_in;
   logic        res_ff, res_in;
   logic signed [15:0] ay_ff, az_ff;

   logic signed [15:0] ax, ay, az;
   logic [31:0] yy, zz, xx;
   logic [35:0] rad;
   logic sq_start, sq_done, dv_start, dv_done;
   logic [17:0] sq_root;
   logic [31:0] dv_quot;
   logic [15:0] old_rd [3];
   logic [NW-1:0] len_eff;

   assign ax = req_tdata[15:0];
   assign ay = req_tdata[31:16];
   assign az = req_tdata[47:32];
   assign xx = 32'(mag_ff[0] * mag_ff[0]);
   assign yy = 32'(ay_ff * ay_ff);
   assign zz = 32'(az_ff * az_ff);

   assign rad = (state_ff == S_SQ1) ? 36'(yy) + 36'(zz)
                                    : 36'(yy) + 36'(zz) + 36'(xx);

   assign len_eff = (wlen_ff == '0) ? NW'(1)
                  : (32'(wlen_ff) > 32'(MAX_WINDOW)) ? NW'(MAX_WINDOW) : NW'(wlen_ff);

   for (genvar g = 0; g < 3; g++) begin : g_ring
      vrv_ram #(.Width(16), .Depth(1 << AW)) u_ring (
         .clock(clock), .wr_en(state_ff == S_UPD), .wr_addr(pos_ff),
         .wr_data(mag_ff[g]), .rd_addr(pos_ff), .rd_data(old_rd[g]));
   end

   vrv_isqrt u_sqrt (.clock(clock), .reset(reset), .start(sq_start), .radicand(rad),
      .done(sq_done), .root(sq_root));
   vrv_divider #(.NumWidth(NUMW), .DenWidth(DENW)) u_div (.clock(clock),
      .reset(reset), .start(dv_start), .numer(num_ff), .denom(den_ff),
      .done(dv_done), .quot(dv_quot));

   logic [SW-1:0] cs;
   logic [QW-1:0] cq;
   logic [NUMW-1:0] a_prod, b_prod;
   always_comb begin
      cs = sum_ff[ch_ff];
      cq = sq_ff[ch_ff];
      a_prod = NUMW'(cq) * NUMW'(fill_ff);
      b_prod = NUMW'(cs) * NUMW'(cs);
   end

   always_comb begin
      state_in = state_ff; len_in = len_ff; pos_in = pos_ff; fill_in = fill_ff;
      sum_in = sum_ff; sq_in = sq_ff; mag_in = mag_ff; var_in = var_ff;
      ch_in = ch_ff; full_in = full_ff; num_in = num_ff; den_in = den_ff;
      zero_in = zero_ff; res_in = res_ff;
      sq_start = 1'b0; dv_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               mag_in[0] = ax[15] ? 16'(-ax) : 16'(ax);
               len_in = len_eff;
               full_in = fill_ff >= len_eff;
               state_in = S_SQ1;
               sq_start = 1'b0;
            end
         end
         S_SQ1: begin
            if (!res_ff) begin sq_start = 1'b1; res_in = 1'b1; end
            else if (sq_done) begin
               mag_in[1] = sq_root[15:0]; res_in = 1'b0; state_in = S_SQ2;
            end
         end
         S_SQ2: begin
            if (!res_ff) begin sq_start = 1'b1; res_in = 1'b1; end
            else if (sq_done) begin
               mag_in[2] = sq_root[15:0]; res_in = 1'b0; state_in = S_RD;
            end
         end
         S_RD: state_in = S_RD2;
         S_RD2: state_in = S_UPD;
         S_UPD: begin
            for (int i = 0; i < 3; i++) begin
               sum_in[i] = sum_ff[i] + SW'(mag_ff[i])
                           - (full_ff ? SW'(old_rd[i]) : SW'(0));
               sq_in[i] = sq_ff[i] + QW'(32'(mag_ff[i]) * 32'(mag_ff[i]))
                          - (full_ff ? QW'(32'(old_rd[i]) * 32'(old_rd[i])) : QW'(0));
            end
            pos_in = (32'(pos_ff) + 1 >= 32'(len_ff)) ? '0 : pos_ff + 1'b1;
            if (!full_ff) fill_in = fill_ff + 1'b1;
            ch_in = '0;
            state_in = S_VPREP;
         end
         S_VPREP: begin
            num_in = a_prod;
            den_in = DENW'(fill_ff) * DENW'(fill_ff - 1'b1);
            state_in = S_VMUL;
         end
         S_VMUL: begin
            zero_in = (fill_ff < NW'(2)) || (num_ff <= b_prod);
            num_in = num_ff - b_prod;
            state_in = S_VDIV;
         end
         S_VDIV: begin
            if (zero_ff) begin
               var_in[ch_ff] = '0;
               state_in = (ch_ff == 2'd2) ? S_OUT : S_VPREP;
               ch_in = ch_ff + 1'b1;
            end else begin
               dv_start = 1'b1; state_in = S_VWAIT;
            end
         end
         S_VWAIT: begin
            if (dv_done) begin
               var_in[ch_ff] = dv_quot;
               state_in = (ch_ff == 2'd2) ? S_OUT : S_VPREP;
               ch_in = ch_ff + 1'b1;
            end
         end
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; wlen_ff <= WindowReset; pos_ff <= '0; fill_ff <= '0;
         res_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin sum_ff[i] <= '0; sq_ff[i] <= '0; end
      end else if (csr_valid && csr_ready) begin
         wlen_ff <= csr_data; pos_ff <= '0; fill_ff <= '0;
         for (int i = 0; i < 3; i++) begin sum_ff[i] <= '0; sq_ff[i] <= '0; end
      end else begin
         state_ff <= state_in; pos_ff <= pos_in; fill_ff <= fill_in; res_ff <= res_in;
         sum_ff <= sum_in; sq_ff <= sq_in;
      end
      len_ff <= len_in; mag_ff <= mag_in; var_ff <= var_in; ch_ff <= ch_in;
      full_ff <= full_in; num_ff <= num_in; den_ff <= den_in; zero_ff <= zero_in;
      if (req_tvalid && req_tready) begin ay_ff <= ay; az_ff <= az; end
   end

   assign req_tready = (state_ff == S_IDLE);
   // hold the register write off while a sample is offered
   assign csr_ready  = (state_ff == S_IDLE) && !req_tvalid;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {var_ff[2], mag_ff[2], var_ff[1], mag_ff[1], var_ff[0], mag_ff[0]};
endmodule
`default_nettype wire

// ===== src/vrv_checker.sv =====
// Port-level checker for the rolling variance block, bound to the top level
`default_nettype none
`include "vibration_rolling_variance_assert.svh"
module vrv_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [143:0] rsp_tdata,
   input wire logic         csr_ready
);
   `VRV_ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp_tvalid, !req_tready)
   `VRV_ASSERT_NEXT(a_accept_then_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `VRV_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `VRV_ASSERT_IMPL(a_csr_idle, clock, reset, csr_ready, req_tready)
endmodule
bind vibration_rolling_variance vrv_checker u_vrv_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .csr_ready(csr_ready));
`default_nettype wire
